// File: src/kvlp_pkg.sv
// Shared types and constants for the key/value line parser.
`default_nettype none

package kvlp_pkg;

   localparam int NAME_MAX_DEF  = 16;
   localparam int VALUE_MAX_DEF = 32;
   localparam int LIMIT_MAX     = 32;
   localparam int CNT_W         = $clog2(LIMIT_MAX + 1);
   localparam int LINE_W        = 16;
   localparam int CMD_DEPTH     = 2;
   localparam int OUT_DEPTH     = 4;

   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_PAIR      = 2'd0,
      OP_PAIR_DONE = 2'd1,
      OP_ERROR     = 2'd2,
      OP_DONE      = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CNT_W-1:0]  name_cnt;
      logic [CNT_W-1:0]  val_cnt;
      logic [LINE_W-1:0] line;
   } cmd_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        char_out;
      logic [LINE_W-1:0] line_number;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/kvlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kvlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/kvlp_fifo.sv
// Small register FIFO used for the command queue and the result queue.
`default_nettype none

module kvlp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               push_data,
   input  wire logic                           pop,
   output logic      [WIDTH-1:0]               pop_data,
   output logic                                empty,
   output logic                                full,
   output logic      [$clog2(DEPTH + 1)-1:0]   count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: src/kvlp_front.sv
// Front end: takes stream bytes, tracks parse mode, fills the stores, queues commands.
`default_nettype none

module kvlp_front #(
   parameter int NAME_MAX  = kvlp_pkg::NAME_MAX_DEF,
   parameter int VALUE_MAX = kvlp_pkg::VALUE_MAX_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic [7:0]                                    req_data_byte,
   input  wire logic                                          req_end_of_input,
   input  wire logic                                          req_push,
   output logic                                               req_full,
   output logic                                               cmd_push,
   output kvlp_pkg::cmd_type                                  cmd_data,
   input  wire logic                                          cmd_full,
   output logic                                               name_we,
   output logic [((NAME_MAX > 1) ? $clog2(NAME_MAX) : 1)-1:0]   name_waddr,
   output logic                                               val_we,
   output logic [((VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1)-1:0] val_waddr,
   output logic [7:0]                                         wdata,
   input  wire logic                                          pair_release
);

   import kvlp_pkg::*;

   localparam int NCW = $clog2(NAME_MAX + 1);
   localparam int VCW = $clog2(VALUE_MAX + 1);
   localparam int NAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int VAW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   typedef enum logic [1:0] {
      MODE_NAME    = 2'd0,
      MODE_VALUE   = 2'd1,
      MODE_COMMENT = 2'd2
   } mode_type;

   function automatic logic name_char_ok(input logic [7:0] c);
      return (c == CH_UNDER) ||
             (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39);
   endfunction

   mode_type          mode_ff, mode_in;
   logic [NCW-1:0]    name_cnt_ff, name_cnt_in;
   logic [VCW-1:0]    val_cnt_ff, val_cnt_in;
   logic [LINE_W-1:0] line_ff, line_in, line_next;
   logic              halted_ff, halted_in;
   logic              busy_ff, busy_in;
   logic              accept;
   logic              fail;

   assign req_full   = cmd_full || busy_ff;
   assign accept     = req_push && !req_full;
   assign line_next  = (line_ff == '1) ? line_ff : line_ff + 1'b1;
   assign name_waddr = name_cnt_ff[NAW-1:0];
   assign val_waddr  = val_cnt_ff[VAW-1:0];
   assign wdata      = req_data_byte;

   always_comb begin
      mode_in           = mode_ff;
      name_cnt_in       = name_cnt_ff;
      val_cnt_in        = val_cnt_ff;
      line_in           = line_ff;
      halted_in         = halted_ff;
      busy_in           = busy_ff && !pair_release;
      cmd_push          = 1'b0;
      cmd_data.op       = OP_ERROR;
      cmd_data.name_cnt = CNT_W'(name_cnt_ff);
      cmd_data.val_cnt  = CNT_W'(val_cnt_ff);
      cmd_data.line     = line_ff;
      name_we           = 1'b0;
      val_we            = 1'b0;
      fail              = 1'b0;

      if (accept && !halted_ff) begin
         if (req_end_of_input) begin
            cmd_push    = 1'b1;
            halted_in   = 1'b1;
            if (mode_ff == MODE_VALUE) begin
               cmd_data.op = OP_PAIR_DONE;
               busy_in     = 1'b1;
            end else begin
               cmd_data.op = OP_DONE;
            end
         end else begin
            unique case (mode_ff)
               MODE_NAME: begin
                  if (req_data_byte == CH_EQUALS) begin
                     if (name_cnt_ff == '0) begin
                        fail = 1'b1;
                     end else begin
                        mode_in    = MODE_VALUE;
                        val_cnt_in = '0;
                     end
                  end else if (req_data_byte == CH_HASH) begin
                     mode_in = MODE_COMMENT;
                  end else if (req_data_byte == CH_CR && name_cnt_ff == '0) begin
                     mode_in = MODE_NAME;
                  end else if (req_data_byte == CH_LF && name_cnt_ff == '0) begin
                     line_in = line_next;
                  end else if (name_char_ok(req_data_byte)) begin
                     if (name_cnt_ff == NCW'(NAME_MAX)) begin
                        fail = 1'b1;
                     end else begin
                        name_we     = 1'b1;
                        name_cnt_in = name_cnt_ff + 1'b1;
                     end
                  end else begin
                     fail = 1'b1;
                  end
               end
               MODE_VALUE: begin
                  if (req_data_byte == CH_LF) begin
                     cmd_push    = 1'b1;
                     cmd_data.op = OP_PAIR;
                     busy_in     = 1'b1;
                     mode_in     = MODE_NAME;
                     name_cnt_in = '0;
                     val_cnt_in  = '0;
                     line_in     = line_next;
                  end else if (req_data_byte == CH_CR) begin
                     mode_in = MODE_VALUE;
                  end else if (val_cnt_ff == VCW'(VALUE_MAX)) begin
                     fail = 1'b1;
                  end else begin
                     val_we     = 1'b1;
                     val_cnt_in = val_cnt_ff + 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (req_data_byte == CH_LF) begin
                     mode_in = MODE_NAME;
                     line_in = line_next;
                  end
               end
               default: begin
                  mode_in = MODE_NAME;
               end
            endcase
            if (fail) begin
               cmd_push    = 1'b1;
               cmd_data.op = OP_ERROR;
               halted_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NAME;
         name_cnt_ff <= '0;
         val_cnt_ff  <= '0;
         line_ff     <= LINE_W'(1);
         halted_ff   <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         name_cnt_ff <= name_cnt_in;
         val_cnt_ff  <= val_cnt_in;
         line_ff     <= line_in;
         halted_ff   <= halted_in;
         busy_ff     <= busy_in;
      end
   end

   // The stores must not change while the back end still reads a pair.
   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(name_we || val_we))
      else $error("store written while a pair is being emitted");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> (halted_ff && !cmd_push))
      else $error("halted parser produced a command");

endmodule

`default_nettype wire

// File: src/kvlp_back.sv
// Back end: carries out queued commands, reading the stores and filling the result queue.
`default_nettype none

module kvlp_back #(
   parameter int NAME_MAX  = kvlp_pkg::NAME_MAX_DEF,
   parameter int VALUE_MAX = kvlp_pkg::VALUE_MAX_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          cmd_empty,
   input  wire kvlp_pkg::cmd_type                             cmd_data,
   output logic                                               cmd_pop,
   output logic                                               name_re,
   output logic [((NAME_MAX > 1) ? $clog2(NAME_MAX) : 1)-1:0]   name_raddr,
   input  wire logic [7:0]                                    name_rdata,
   output logic                                               val_re,
   output logic [((VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1)-1:0] val_raddr,
   input  wire logic [7:0]                                    val_rdata,
   output logic                                               out_push,
   output kvlp_pkg::rsp_type                                  out_data,
   input  wire logic [$clog2(kvlp_pkg::OUT_DEPTH + 1)-1:0]    out_count,
   output logic                                               pair_release
);

   import kvlp_pkg::*;

   localparam int NAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int VAW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

   typedef enum logic [1:0] {
      B_IDLE  = 2'd0,
      B_NAME  = 2'd1,
      B_VALUE = 2'd2,
      B_TERM  = 2'd3
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  v_ff, v_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  idx_next;
   logic [LINE_W-1:0] line_ff, line_in;
   kind_type          term_kind_ff, term_kind_in;
   logic              rd_pending_ff, rd_pending_in;
   logic              rd_sel_val_ff, rd_sel_val_in;
   logic              rd_last_ff, rd_last_in;
   logic              can_issue;
   logic              room;

   assign idx_next   = idx_ff + 1'b1;
   assign name_raddr = idx_ff[NAW-1:0];
   assign val_raddr  = idx_ff[VAW-1:0];
   // One read may be in flight; count it against the result queue space.
   assign can_issue  = (32'(out_count) + 32'(rd_pending_ff)) < OUT_DEPTH;
   assign room       = 32'(out_count) < OUT_DEPTH;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      n_in          = n_ff;
      v_in          = v_ff;
      idx_in        = idx_ff;
      line_in       = line_ff;
      term_kind_in  = term_kind_ff;
      rd_pending_in = 1'b0;
      rd_sel_val_in = rd_sel_val_ff;
      rd_last_in    = rd_last_ff;
      cmd_pop       = 1'b0;
      name_re       = 1'b0;
      val_re        = 1'b0;
      pair_release  = 1'b0;
      out_push      = 1'b0;
      out_data.kind        = term_kind_ff;
      out_data.char_out    = '0;
      out_data.line_number = line_ff;
      out_data.last        = 1'b1;

      if (rd_pending_ff) begin
         out_push          = 1'b1;
         out_data.kind     = rd_sel_val_ff ? KIND_VALUE : KIND_NAME;
         out_data.char_out = rd_sel_val_ff ? val_rdata : name_rdata;
         out_data.last     = rd_last_ff;
      end

      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               op_in   = cmd_data.op;
               n_in    = cmd_data.name_cnt;
               v_in    = cmd_data.val_cnt;
               line_in = cmd_data.line;
               idx_in  = '0;
               if (cmd_data.op == OP_PAIR || cmd_data.op == OP_PAIR_DONE) begin
                  term_kind_in = KIND_DONE;
                  state_in     = B_NAME;
               end else begin
                  term_kind_in = (cmd_data.op == OP_ERROR) ? KIND_ERROR : KIND_DONE;
                  state_in     = B_TERM;
               end
            end
         end
         B_NAME: begin
            if (can_issue) begin
               name_re       = 1'b1;
               rd_pending_in = 1'b1;
               rd_sel_val_in = 1'b0;
               rd_last_in    = (idx_next == n_ff) && (v_ff == '0);
               if (idx_next == n_ff) begin
                  idx_in = '0;
                  if (v_ff != '0) begin
                     state_in = B_VALUE;
                  end else begin
                     pair_release = 1'b1;
                     state_in     = (op_ff == OP_PAIR_DONE) ? B_TERM : B_IDLE;
                  end
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         B_VALUE: begin
            if (can_issue) begin
               val_re        = 1'b1;
               rd_pending_in = 1'b1;
               rd_sel_val_in = 1'b1;
               rd_last_in    = (idx_next == v_ff);
               if (idx_next == v_ff) begin
                  idx_in       = '0;
                  pair_release = 1'b1;
                  state_in     = (op_ff == OP_PAIR_DONE) ? B_TERM : B_IDLE;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         B_TERM: begin
            // Wait for the last pair byte to land before the closing request.
            if (!rd_pending_ff && room) begin
               out_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rd_pending_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pending_ff <= rd_pending_in;
      end
      op_ff         <= op_in;
      n_ff          <= n_in;
      v_ff          <= v_in;
      idx_ff        <= idx_in;
      line_ff       <= line_in;
      term_kind_ff  <= term_kind_in;
      rd_sel_val_ff <= rd_sel_val_in;
      rd_last_ff    <= rd_last_in;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> room)
      else $error("result pushed into a full queue");

   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      (name_re || val_re) |=> (out_push && out_data.kind != KIND_ERROR))
      else $error("store read did not produce a character result");

endmodule

`default_nettype wire

// File: src/key_value_line_parser.sv
// Top level of the key/value line parser: front end, command queue, stores, back end.
//
//   channel   direction  handshake            payload
//   req_      in         req_push / req_full   req_data_byte, req_end_of_input
//   rsp_      out        rsp_pop / rsp_empty   rsp_kind, rsp_char_out, rsp_line_number, rsp_last
//
// Ordinary bytes are taken one per cycle while req_full is low. A completed pair holds
// req_full high until the back end issues the read of its last stored byte, which takes
// longer while the result queue is full, as the back end reads the stores through their
// single read port and fills the four-entry result queue.
// Reset is synchronous; the stores are not cleared and hold data only once written.
// A full result queue stalls the back end; a full command queue stalls the front end.
`default_nettype none

module key_value_line_parser #(
   parameter int NAME_MAX  = kvlp_pkg::NAME_MAX_DEF,
   parameter int VALUE_MAX = kvlp_pkg::VALUE_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_input,
   input  wire logic        req_push,
   output logic             req_full,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_char_out,
   output logic [15:0]      rsp_line_number,
   output logic             rsp_last,
   output logic             rsp_empty,
   input  wire logic        rsp_pop
);

   import kvlp_pkg::*;

   localparam int NAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int VAW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
   localparam int OCW = $clog2(OUT_DEPTH + 1);
   localparam int QCW = $clog2(CMD_DEPTH + 1);

   cmd_type        cmd_wdata, cmd_rdata;
   logic           cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic [QCW-1:0] cmd_count;
   logic           name_we, val_we, name_re, val_re;
   logic [NAW-1:0] name_waddr, name_raddr;
   logic [VAW-1:0] val_waddr, val_raddr;
   logic [7:0]     wdata, name_rdata, val_rdata;
   logic           pair_release;
   rsp_type        out_wdata, out_rdata;
   logic           out_push, out_full;
   logic [OCW-1:0] out_count;

   kvlp_front #(.NAME_MAX(NAME_MAX), .VALUE_MAX(VALUE_MAX)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .req_push         (req_push),
      .req_full         (req_full),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_wdata),
      .cmd_full         (cmd_full),
      .name_we          (name_we),
      .name_waddr       (name_waddr),
      .val_we           (val_we),
      .val_waddr        (val_waddr),
      .wdata            (wdata),
      .pair_release     (pair_release)
   );

   kvlp_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(CMD_DEPTH)) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .empty     (cmd_empty),
      .full      (cmd_full),
      .count     (cmd_count)
   );

   kvlp_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_name_ram (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (name_waddr),
      .wr_data (wdata),
      .rd_en   (name_re),
      .rd_addr (name_raddr),
      .rd_data (name_rdata)
   );

   kvlp_ram #(.WIDTH(8), .DEPTH(VALUE_MAX)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (wdata),
      .rd_en   (val_re),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   kvlp_back #(.NAME_MAX(NAME_MAX), .VALUE_MAX(VALUE_MAX)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_empty),
      .cmd_data     (cmd_rdata),
      .cmd_pop      (cmd_pop),
      .name_re      (name_re),
      .name_raddr   (name_raddr),
      .name_rdata   (name_rdata),
      .val_re       (val_re),
      .val_raddr    (val_raddr),
      .val_rdata    (val_rdata),
      .out_push     (out_push),
      .out_data     (out_wdata),
      .out_count    (out_count),
      .pair_release (pair_release)
   );

   kvlp_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(OUT_DEPTH)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .pop       (rsp_pop),
      .pop_data  (out_rdata),
      .empty     (rsp_empty),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_kind        = out_rdata.kind;
   assign rsp_char_out    = out_rdata.char_out;
   assign rsp_line_number = out_rdata.line_number;
   assign rsp_last        = out_rdata.last;

   a_cmd_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (!cmd_full && 32'(cmd_count) < CMD_DEPTH))
      else $error("command pushed into a full queue");

   a_rsp_bounded: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

endmodule

`default_nettype wire
